// ===== rtl/tccw_pkg.sv =====
// Shared constants, codes and word types of the text console character writer.
// Depends on nothing; every other file of the block imports it.
package tccw_pkg;

	// Screen geometry.
	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int CELLS       = ROWS * COLUMNS;
	localparam int SCROLL_MOVE = CELLS - COLUMNS;
	localparam int TAB_STEP    = 4;

	// Cell address width, cursor width (holds a cursor that ran a tab past the end)
	// and column width (holds a column plus a tab step).
	localparam int AW    = $clog2(CELLS);
	localparam int CUR_W = $clog2(CELLS + TAB_STEP);
	localparam int COL_W = $clog2(COLUMNS + TAB_STEP);

	// Command queue depth.
	localparam int QDEPTH = 2;

	localparam logic [7:0] DEFAULT_COLOR_RST = 8'd15;

	// Function codes of a command word.
	localparam logic [1:0] FUNC_PUT    = 2'd0;
	localparam logic [1:0] FUNC_CLEAR  = 2'd1;
	localparam logic [1:0] FUNC_SETCUR = 2'd2;
	localparam logic [1:0] FUNC_READ   = 2'd3;

	// Control characters.
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_BLANK     = 8'd32;

	// Operation classes decided by the front end.
	typedef enum logic [3:0] {
		OP_CHAR,
		OP_NEWLINE,
		OP_RETURN,
		OP_TAB,
		OP_BACKSPACE,
		OP_CLEAR,
		OP_SETCUR,
		OP_READ,
		OP_READ_NONE
	} op_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  character;
		logic [7:0]  color;
		logic [10:0] position;
	} cmd_t;

	typedef struct packed {
		logic [10:0] cursor;
		logic [15:0] cell_data;
		logic        scrolled;
	} res_t;

	// Queue entry: the classified operation with a clamped position.
	typedef struct packed {
		op_t              op;
		logic [7:0]       character;
		logic [7:0]       color;
		logic [CUR_W-1:0] position;
	} qent_t;

endpackage

// ===== rtl/tccw_front.sv =====
// Front end: accepts command words and classifies them into queue entries.
// Depends on tccw_pkg.
module tccw_front import tccw_pkg::*; (
	input  logic  start,
	output logic  busy,
	input  cmd_t  cmd,
	input  logic  init_busy,
	input  logic  q_full,
	output logic  push,
	output qent_t entry
);

	assign busy = init_busy || q_full;
	assign push = start && !busy;

	always_comb begin
		entry.character = cmd.character;
		entry.color     = cmd.color;
		// Set cursor saturates to the last cell.
		if (32'(cmd.position) < CELLS) begin
			entry.position = CUR_W'(cmd.position);
		end else begin
			entry.position = CUR_W'(CELLS - 1);
		end
		case (cmd.func)
			FUNC_PUT: begin
				case (cmd.character)
					CH_NEWLINE:   entry.op = OP_NEWLINE;
					CH_RETURN:    entry.op = OP_RETURN;
					CH_TAB:       entry.op = OP_TAB;
					CH_BACKSPACE: entry.op = OP_BACKSPACE;
					default:      entry.op = OP_CHAR;
				endcase
			end
			FUNC_CLEAR:  entry.op = OP_CLEAR;
			FUNC_SETCUR: entry.op = OP_SETCUR;
			FUNC_READ: begin
				// A read beyond the screen returns zero and touches nothing.
				entry.op = (32'(cmd.position) < CELLS) ? OP_READ : OP_READ_NONE;
			end
			default: entry.op = OP_READ_NONE;
		endcase
	end

endmodule

// ===== rtl/tccw_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on tccw_pkg for the entry type and the depth.
module tccw_queue import tccw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	input  logic  pop,
	output qent_t head,
	output logic  valid,
	output logic  full
);

	localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	qent_t            slot_q [QDEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   cnt_q;

	assign head  = slot_q[rd_ptr_q];
	assign valid = (cnt_q != '0);
	assign full  = (cnt_q == QCW'(QDEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tccw_back.sv =====
// Back end: holds the cell memory, the cursor and the color register, and
// carries out queued operations, including the scroll, clear and reset sweeps.
// Depends on tccw_pkg.
module tccw_back import tccw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  qent_t      q_head,
	output logic       q_pop,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	output logic       init_busy,
	output logic       done,
	output res_t       result
);

	typedef enum logic [2:0] {S_IDLE, S_RDWAIT, S_SETCUR, S_SCROLL, S_FILL} state_t;
	typedef enum logic [1:0] {FM_INIT, FM_CLEAR, FM_SCROLL} fill_mode_t;

	state_t           state_q;
	fill_mode_t       fill_mode_q;
	logic [CUR_W-1:0] cursor_q;
	logic [CUR_W-1:0] rowb_q;
	logic [COL_W-1:0] col_q;
	logic [CUR_W-1:0] idx_q;
	logic [7:0]       fill_color_q;
	logic [7:0]       defcol_q;
	logic             mv_s1;
	logic [AW-1:0]    mv_addr_s1;
	logic             done_q;
	res_t             res_q;

	logic [15:0]      mem [CELLS];
	logic [15:0]      rd_q;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [15:0]      wr_data;
	logic             wr_en;

	logic [CUR_W-1:0] put_cur;
	logic [CUR_W-1:0] put_rb;
	logic [COL_W-1:0] put_col;
	logic [COL_W-1:0] tab_col;
	logic             put_we;
	logic [AW-1:0]    put_addr;
	logic [15:0]      put_data;
	logic             fill_last;

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign init_busy = (state_q == S_FILL) && (fill_mode_q == FM_INIT);
	assign done      = done_q;
	assign result    = res_q;
	assign fill_last = (idx_q == CUR_W'(CELLS - 1));

	// Cursor movement of a put, worked out on the head of the queue.
	always_comb begin
		put_cur  = cursor_q;
		put_rb   = rowb_q;
		put_col  = col_q;
		put_we   = 1'b0;
		put_addr = AW'(cursor_q);
		put_data = {q_head.color, q_head.character};
		tab_col  = col_q + COL_W'(TAB_STEP) - COL_W'(cursor_q[1:0]);
		case (q_head.op)
			OP_CHAR: begin
				put_we  = 1'b1;
				put_cur = cursor_q + 1'b1;
				if (col_q == COL_W'(COLUMNS - 1)) begin
					put_col = '0;
					put_rb  = rowb_q + CUR_W'(COLUMNS);
				end else begin
					put_col = col_q + 1'b1;
				end
			end
			OP_NEWLINE: begin
				put_cur = rowb_q + CUR_W'(COLUMNS);
				put_rb  = rowb_q + CUR_W'(COLUMNS);
				put_col = '0;
			end
			OP_RETURN: begin
				put_cur = rowb_q;
				put_col = '0;
			end
			OP_TAB: begin
				put_cur = (cursor_q + CUR_W'(TAB_STEP)) & ~CUR_W'(TAB_STEP - 1);
				if (tab_col >= COL_W'(COLUMNS)) begin
					put_col = tab_col - COL_W'(COLUMNS);
					put_rb  = rowb_q + CUR_W'(COLUMNS);
				end else begin
					put_col = tab_col;
				end
			end
			OP_BACKSPACE: begin
				if (cursor_q != '0) begin
					put_we   = 1'b1;
					put_cur  = cursor_q - 1'b1;
					put_addr = AW'(cursor_q - 1'b1);
					put_data = {q_head.color, CH_BLANK};
					if (col_q == '0) begin
						put_col = COL_W'(COLUMNS - 1);
						put_rb  = rowb_q - CUR_W'(COLUMNS);
					end else begin
						put_col = col_q - 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// One write port: the scroll copy has priority, then sweeps, then puts.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = put_addr;
		wr_data = put_data;
		if (mv_s1) begin
			wr_en   = 1'b1;
			wr_addr = mv_addr_s1;
			wr_data = rd_q;
		end else if (state_q == S_FILL) begin
			wr_en   = 1'b1;
			wr_addr = AW'(idx_q);
			wr_data = {fill_color_q, CH_BLANK};
		end else if (q_pop) begin
			wr_en = put_we;
		end
	end

	always_comb begin
		if (state_q == S_SCROLL) begin
			rd_addr = AW'(idx_q + CUR_W'(COLUMNS));
		end else begin
			rd_addr = AW'(q_head.position);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_FILL;
			fill_mode_q  <= FM_INIT;
			cursor_q     <= '0;
			rowb_q       <= '0;
			col_q        <= '0;
			idx_q        <= '0;
			fill_color_q <= DEFAULT_COLOR_RST;
			defcol_q     <= DEFAULT_COLOR_RST;
			mv_s1        <= 1'b0;
			mv_addr_s1   <= '0;
			done_q       <= 1'b0;
			res_q        <= '0;
		end else begin
			done_q <= 1'b0;
			mv_s1  <= 1'b0;
			if (cfg_we) begin
				defcol_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						case (q_head.op)
							OP_CHAR, OP_NEWLINE, OP_RETURN, OP_TAB, OP_BACKSPACE: begin
								cursor_q <= put_cur;
								rowb_q   <= put_rb;
								col_q    <= put_col;
								if (put_cur >= CUR_W'(CELLS)) begin
									state_q <= S_SCROLL;
									idx_q   <= '0;
								end else begin
									done_q          <= 1'b1;
									res_q.cursor    <= 11'(put_cur);
									res_q.cell_data <= '0;
									res_q.scrolled  <= 1'b0;
								end
							end
							OP_CLEAR: begin
								state_q      <= S_FILL;
								fill_mode_q  <= FM_CLEAR;
								fill_color_q <= defcol_q;
								idx_q        <= '0;
							end
							OP_SETCUR: begin
								cursor_q <= q_head.position;
								rowb_q   <= '0;
								state_q  <= S_SETCUR;
							end
							OP_READ: begin
								state_q <= S_RDWAIT;
							end
							default: begin
								done_q          <= 1'b1;
								res_q.cursor    <= 11'(cursor_q);
								res_q.cell_data <= '0;
								res_q.scrolled  <= 1'b0;
							end
						endcase
					end
				end
				S_RDWAIT: begin
					done_q          <= 1'b1;
					res_q.cursor    <= 11'(cursor_q);
					res_q.cell_data <= rd_q;
					res_q.scrolled  <= 1'b0;
					state_q         <= S_IDLE;
				end
				S_SETCUR: begin
					// Find the row start by stepping one row per cycle.
					if (rowb_q + CUR_W'(COLUMNS) <= cursor_q) begin
						rowb_q <= rowb_q + CUR_W'(COLUMNS);
					end else begin
						col_q           <= COL_W'(cursor_q - rowb_q);
						done_q          <= 1'b1;
						res_q.cursor    <= 11'(cursor_q);
						res_q.cell_data <= '0;
						res_q.scrolled  <= 1'b0;
						state_q         <= S_IDLE;
					end
				end
				S_SCROLL: begin
					// Read the cell one row ahead now and write it back in the next cycle.
					if (idx_q < CUR_W'(SCROLL_MOVE)) begin
						mv_s1      <= 1'b1;
						mv_addr_s1 <= AW'(idx_q);
						idx_q      <= idx_q + 1'b1;
					end else begin
						state_q      <= S_FILL;
						fill_mode_q  <= FM_SCROLL;
						fill_color_q <= defcol_q;
					end
				end
				S_FILL: begin
					if (!mv_s1) begin
						idx_q <= idx_q + 1'b1;
						if (fill_last) begin
							state_q <= S_IDLE;
							case (fill_mode_q)
								FM_CLEAR: begin
									cursor_q        <= '0;
									rowb_q          <= '0;
									col_q           <= '0;
									done_q          <= 1'b1;
									res_q.cursor    <= '0;
									res_q.cell_data <= '0;
									res_q.scrolled  <= 1'b0;
								end
								FM_SCROLL: begin
									cursor_q        <= CUR_W'(SCROLL_MOVE);
									rowb_q          <= CUR_W'(SCROLL_MOVE);
									col_q           <= '0;
									done_q          <= 1'b1;
									res_q.cursor    <= 11'(SCROLL_MOVE);
									res_q.cell_data <= '0;
									res_q.scrolled  <= 1'b1;
								end
								default: ;
							endcase
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// Between operations the cursor is on screen and split consistently into row and column.
	a_cursor_split: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
			(32'(col_q) < COLUMNS) && (32'(rowb_q) + 32'(col_q) == 32'(cursor_q))
			&& (32'(cursor_q) < CELLS))
		else $error("cursor, row start and column disagree");

	// A scroll always leaves the cursor at the start of the last row.
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.scrolled) |-> (res_q.cursor == 11'(SCROLL_MOVE)))
		else $error("scroll result with wrong cursor");

	// The delayed copy write only follows a scroll read.
	a_copy_origin: assert property (@(posedge clk) disable iff (!arst_n)
		mv_s1 |-> ($past(state_q) == S_SCROLL))
		else $error("copy write without a scroll read");

	// No result word while the reset sweep is still running.
	a_no_result_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !done_q)
		else $error("result during reset sweep");
`endif

endmodule

// ===== rtl/text_console_char_writer.sv =====
// Top level of the text console character writer: front end, command queue
// and back end with the cell memory. Depends on tccw_pkg and the tccw_* modules.
//
// Usage. A command word (func, character, color, position) is taken at a rising
// edge with start high and busy low. Every command gives exactly one result word
// (cursor, cell_data, scrolled), shown for one cycle with done high; the receiver
// cannot hold it off, so it must sample every cycle in which done is high.
// The default color register is written over its own channel: cfg_data is taken
// at an edge with cfg_valid and cfg_ready high, and cfg_ready is always high.
// Write it only while no command is outstanding.
//
// Timing. A command enters a two-word queue; the back end takes one word per
// cycle when free. A plain put, return, newline, tab, backspace or an
// out-of-range read gives its result straight from the idle state; a read
// waits in S_RDWAIT for the memory word; a set cursor steps the row start from
// the top, row by row, to the row of the new cursor. A put that runs off the end
// scrolls: the memory port copies one cell per cycle and then blanks the last
// row. A clear blanks one cell per cycle. The single write port of the cell
// memory sets these rates; busy rises when the queue is full.
//
// Reset. After arst_n is released the memory is blanked in the reset color, one
// cell per cycle over all ROWS*COLUMNS cells (2000 at 80 by 25), with busy high.
module text_console_char_writer import tccw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	output logic       done,
	output res_t       result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic  init_busy;
	logic  q_full;
	logic  q_valid;
	logic  q_push;
	logic  q_pop;
	qent_t q_in;
	qent_t q_head;

	// The register is always free to take a write word.
	assign cfg_ready = 1'b1;

	tccw_front u_front (
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.init_busy (init_busy),
		.q_full    (q_full),
		.push      (q_push),
		.entry     (q_in)
	);

	tccw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.valid     (q_valid),
		.full      (q_full)
	);

	tccw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.init_busy (init_busy),
		.done      (done),
		.result    (result)
	);

endmodule
